### sv/ultrasonic_echo_ranger_top_macros.svh
// assertion macros shared by the ultrasonic echo ranger checker
// expects a clk and an active-low rst_n in the scope of use
`ifndef ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH

// same-cycle implication, muted during reset
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication, muted during reset
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies
`default_nettype none

package uer_pkg;

  localparam int COUNT_BITS = 22;
  localparam int REG_W      = 22;
  localparam int IDX_W      = 3;
  localparam int DIST_W     = 17;
  localparam int STAT_W     = 2;
  localparam int REM_W      = 13;

  // distance = width * CM_NUM / CM_DEN, built up one tick at a time
  localparam logic [REM_W-1:0] CM_NUM = REM_W'(100);
  localparam logic [REM_W-1:0] CM_DEN = REM_W'(5882);

  localparam logic [IDX_W-1:0] REG_PRE_LOW   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_TRIG_HIGH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_POST_LOW  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TIMEOUT   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_HOLDOFF   = IDX_W'(4);

  localparam logic [REG_W-1:0] RST_PRE_LOW   = REG_W'(2000);
  localparam logic [REG_W-1:0] RST_TRIG_HIGH = REG_W'(10000);
  localparam logic [REG_W-1:0] RST_POST_LOW  = REG_W'(2000);
  localparam logic [REG_W-1:0] RST_TIMEOUT   = REG_W'(1000000);
  localparam logic [REG_W-1:0] RST_HOLDOFF   = REG_W'(25000);

  localparam logic [STAT_W-1:0] STAT_OK       = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_NO_ECHO  = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = STAT_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_HIGH = 3'd2,
    PH_POST = 3'd3,
    PH_WAIT = 3'd4,
    PH_MEAS = 3'd5,
    PH_HOLD = 3'd6
  } phase_t;

endpackage

`default_nettype wire

### sv/ultrasonic_echo_ranger_top.sv
// ultrasonic range controller: trigger pulse, echo timing, distance in cm
// depends on uer_pkg
`default_nettype none

// One input transaction is one microsecond tick (start request plus the
// sampled echo level) and yields exactly one result transaction. The block
// takes one transaction per clock cycle while the result side does not
// stall; each passes the input register, then the result register, waiting
// there under a result stall. in_stall comes from a flop: a one-entry skid
// stage catches the transaction that arrives while the input register
// cannot move, so the input side never waits combinationally on out_stall.
// Per tick the controller first leaves any timed phase whose time has run
// out (zero-length phases take no tick), may start a new measurement from
// idle, then counts trigger low / high / low, waits for echo with a
// timeout, and measures the echo width with the same timeout. The distance
// is built while the echo is high: a remainder register gains 100 per tick
// and wraps at 5882, bumping the quotient, so no divider is needed. The user
// must write configuration only while the block is idle; nothing enforces it.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration port
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_start_request,
  input  wire logic              in_echo_level,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_trigger_out,
  output logic                   out_busy_res,
  output logic                   out_done_res,
  output logic [DIST_W-1:0]      out_distance_cm,
  output logic [STAT_W-1:0]      out_status
);

  typedef struct packed {
    phase_t                ph;
    logic [COUNT_BITS-1:0] tc;
  } ph_tc_t;

  // configuration registers
  logic [REG_W-1:0] pre_low_r, trig_high_r, post_low_r, timeout_r, holdoff_r;

  // skid stage and input register
  logic skid_v_r, s1_v_r;
  logic skid_start_r, skid_echo_r, s1_start_r, s1_echo_r;

  // controller state
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] tc_r, tc_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DIST_W-1:0]     quo_r, quo_nxt;

  // result register
  logic              out_v_r;
  logic              trig_r, busy_r, done_r;
  logic [DIST_W-1:0] dist_r;
  logic [STAT_W-1:0] stat_r;
  logic              trig_nxt, done_nxt;
  logic [DIST_W-1:0] dist_nxt;
  logic [STAT_W-1:0] stat_nxt;

  logic in_acc, s1_adv, s1_free;

  // ---------------------------------------------------------------------
  // configuration writes, unknown indexes ignored
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_low_r   <= RST_PRE_LOW;
      trig_high_r <= RST_TRIG_HIGH;
      post_low_r  <= RST_POST_LOW;
      timeout_r   <= RST_TIMEOUT;
      holdoff_r   <= RST_HOLDOFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRE_LOW:   pre_low_r   <= cfg_wdata;
        REG_TRIG_HIGH: trig_high_r <= cfg_wdata;
        REG_POST_LOW:  post_low_r  <= cfg_wdata;
        REG_TIMEOUT:   timeout_r   <= cfg_wdata;
        REG_HOLDOFF:   holdoff_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: skid stage, input register, result register
  // ---------------------------------------------------------------------
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  // input register moves when the result register is empty or being taken
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign s1_free  = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      // skid empties into the input register first, keeping order
      if (skid_v_r) begin
        if (s1_free) skid_v_r <= 1'b0;
      end else if (in_acc && !s1_free) begin
        skid_v_r <= 1'b1;
      end
      if (s1_free) s1_v_r <= skid_v_r || in_acc;
      if (!out_v_r || !out_stall) out_v_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && in_acc && !s1_free) begin
      skid_start_r <= in_start_request;
      skid_echo_r  <= in_echo_level;
    end
    if (s1_free) begin
      if (skid_v_r) begin
        s1_start_r <= skid_start_r;
        s1_echo_r  <= skid_echo_r;
      end else begin
        s1_start_r <= in_start_request;
        s1_echo_r  <= in_echo_level;
      end
    end
  end

  // ---------------------------------------------------------------------
  // tick processing
  // ---------------------------------------------------------------------
  // walk through timed phases whose length is already reached
  function automatic ph_tc_t expire(ph_tc_t cur);
    ph_tc_t             r;
    logic [REG_W-1:0]   len;
    phase_t             nx;
    logic               tmd;
    r = cur;
    for (int i = 0; i < 4; i++) begin
      tmd = 1'b1;
      len = '0;
      nx  = PH_IDLE;
      case (r.ph)
        PH_PRE:  begin len = pre_low_r;   nx = PH_HIGH; end
        PH_HIGH: begin len = trig_high_r; nx = PH_POST; end
        PH_POST: begin len = post_low_r;  nx = PH_WAIT; end
        PH_HOLD: begin len = holdoff_r;   nx = PH_IDLE; end
        default: tmd = 1'b0;
      endcase
      if (tmd && (r.tc >= COUNT_BITS'(len))) begin
        r.ph = nx;
        r.tc = '0;
      end
    end
    return r;
  endfunction

  always_comb begin
    ph_tc_t cur;
    logic   done;
    cur.ph   = phase_r;
    cur.tc   = tc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trig_nxt = 1'b0;
    done     = 1'b0;
    dist_nxt = '0;
    stat_nxt = STAT_OK;

    // an unused phase code falls back to idle
    if (cur.ph > PH_HOLD) begin
      cur.ph = PH_IDLE;
      cur.tc = '0;
    end
    cur = expire(cur);
    if (cur.ph == PH_IDLE && s1_start_r) begin
      cur.ph = PH_PRE;
      cur.tc = '0;
      cur = expire(cur);
    end

    unique case (cur.ph) inside
      PH_PRE, PH_HIGH, PH_POST, PH_HOLD: begin
        if (cur.tc != '1) cur.tc = cur.tc + 1'b1;
        trig_nxt = (cur.ph == PH_HIGH);
      end
      PH_WAIT: begin
        if (s1_echo_r) begin
          cur.ph  = PH_MEAS;
          cur.tc  = COUNT_BITS'(1);
          rem_nxt = CM_NUM;
          quo_nxt = '0;
        end else if (cur.tc >= COUNT_BITS'(timeout_r)) begin
          done     = 1'b1;
          stat_nxt = STAT_NO_ECHO;
        end else begin
          cur.tc = cur.tc + 1'b1;
        end
      end
      PH_MEAS: begin
        if (!s1_echo_r) begin
          done     = 1'b1;
          dist_nxt = quo_r;
        end else if (cur.tc >= COUNT_BITS'(timeout_r)) begin
          done     = 1'b1;
          stat_nxt = STAT_TOO_LONG;
        end else begin
          cur.tc = cur.tc + 1'b1;
          // one more tick of width: remainder gains 100, wraps at 5882
          if ((rem_r + CM_NUM) >= CM_DEN) begin
            rem_nxt = rem_r + CM_NUM - CM_DEN;
            quo_nxt = quo_r + 1'b1;
          end else begin
            rem_nxt = rem_r + CM_NUM;
          end
        end
      end
      default: ;
    endcase

    if (done) begin
      cur.ph = PH_HOLD;
      cur.tc = '0;
    end
    done_nxt  = done;
    phase_nxt = cur.ph;
    tc_nxt    = cur.tc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tc_r    <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      trig_r <= trig_nxt;
      busy_r <= (phase_nxt != PH_IDLE);
      done_r <= done_nxt;
      dist_r <= dist_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_trigger_out = trig_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_distance_cm = dist_r;
  assign out_status      = stat_r;

endmodule

`default_nettype wire

### sv/uer_checker.sv
// port-level checks on the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger_top_macros.svh
`default_nettype none

`include "ultrasonic_echo_ranger_top_macros.svh"

module uer_checker
  import uer_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_trigger_out,
  input wire logic              out_busy_res,
  input wire logic              out_done_res,
  input wire logic [DIST_W-1:0] out_distance_cm,
  input wire logic [STAT_W-1:0] out_status
);

  `UER_ASSERT(a_done_busy, (out_valid && out_done_res) |-> out_busy_res, "done without busy")
  `UER_ASSERT(a_quiet_tick, (out_valid && !out_done_res) |-> (out_status == STAT_OK && out_distance_cm == '0), "result fields set off a done tick")
  `UER_ASSERT(a_timeout_zero, (out_valid && out_status != STAT_OK) |-> (out_done_res && out_distance_cm == '0), "timeout with a distance")
  `UER_ASSERT(a_trig_busy, (out_valid && out_trigger_out) |-> (out_busy_res && !out_done_res), "trigger outside a measurement")
  `UER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_distance_cm) && $stable(out_status) && $stable(out_done_res), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);

`default_nettype wire
